// ===== rtl/subcnt_pkg.sv =====
// Shared types for the substring occurrence counter.
// Holds the queue word and the configuration bundle. No dependencies.
package subcnt_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int PATTERN_BYTES = 16;

   // One classified text byte on its way from the front to the back.
   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
      logic       active;      // byte is part of the string before its terminator
   } item_type;

   typedef struct packed {
      logic [PATTERN_BYTES-1:0][7:0] pattern;
      logic [4:0]                    length;
      logic                          exact_case;
   } cfg_type;

endpackage

// ===== rtl/subcnt_front.sv =====
// Front end: accepts text bytes and marks the ones that belong to the string.
// Depends on subcnt_pkg.
module subcnt_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 req_tlast,
   input  logic                 queue_full,
   output logic                 push,
   output subcnt_pkg::item_type push_item
);
   import subcnt_pkg::*;

   logic terminated_ff;
   logic terminated_in;
   logic seen_zero;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;
   assign seen_zero  = terminated_ff || (req_tdata == 8'd0);

   always_comb begin
      push_item.text_byte = req_tdata;
      push_item.last_byte = req_tlast;
      push_item.active    = !seen_zero;
      terminated_in       = terminated_ff;
      if (push) begin
         // The last word of a buffer starts a fresh string.
         terminated_in = req_tlast ? 1'b0 : seen_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         terminated_ff <= 1'b0;
      end else begin
         terminated_ff <= terminated_in;
      end
   end

endmodule

// ===== rtl/subcnt_queue.sv =====
// Short queue between the front end and the matcher.
// Depends on subcnt_pkg.
module subcnt_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  subcnt_pkg::item_type push_item,
   input  logic                 pop,
   output subcnt_pkg::item_type pop_item,
   output logic                 empty,
   output logic                 full
);
   import subcnt_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   item_type               slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff;
   logic [PTR_W-1:0]       wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff;
   logic [PTR_W-1:0]       rd_ptr_in;
   logic [PTR_W:0]         fill_ff;
   logic [PTR_W:0]         fill_in;

   assign empty    = (fill_ff == '0);
   assign full     = (fill_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign pop_item = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ===== rtl/subcnt_back.sv =====
// Matcher: byte window, parallel pattern compare, overlap guard, counters
// and the result register. Depends on subcnt_pkg.
module subcnt_back #(
   parameter int MAX_PATTERN  = 16,
   parameter int COUNTER_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  subcnt_pkg::cfg_type  cfg,
   input  logic                 item_valid,
   input  subcnt_pkg::item_type item,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,
   output logic                 rsp_tuser,
   output logic                 rsp_tlast
);
   import subcnt_pkg::*;

   localparam int CNT_W = (COUNTER_BITS < 16) ? COUNTER_BITS : 16;
   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET   = 8'h20;

   function automatic logic [7:0] fold(input logic [7:0] c);
      if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
         return c + CASE_OFFSET;
      end
      return c;
   endfunction

   logic [7:0]       window_ff [MAX_PATTERN];
   logic [7:0]       window_in [MAX_PATTERN];
   logic [4:0]       guard_ff;
   logic [4:0]       guard_in;
   logic [15:0]      pos_ff;
   logic [15:0]      pos_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             out_valid_ff;
   logic             out_valid_in;
   logic             hit_ff;
   logic             hit_in;
   logic [15:0]      offset_ff;
   logic [15:0]      offset_in;
   logic [15:0]      total_ff;
   logic [15:0]      total_in;
   logic             eos_ff;
   logic             eos_in;

   logic [4:0]       cap_len;
   logic [4:0]       eff_len;
   logic [7:0]       lane_byte [MAX_PATTERN];
   logic             window_eq;
   logic [16:0]      pos_plus;
   logic             fire;

   assign fire = item_valid && (!out_valid_ff || rsp_tready);
   assign pop  = fire;

   always_comb begin
      // Window as it stands once this byte has shifted in.
      window_in[0] = item.text_byte;
      for (int j = 1; j < MAX_PATTERN; j++) begin
         window_in[j] = window_ff[j-1];
      end

      // Length in use: capped, and cut short at the first zero pattern byte.
      cap_len = (cfg.length > 5'(MAX_PATTERN)) ? 5'(MAX_PATTERN) : cfg.length;
      eff_len = cap_len;
      for (int k = MAX_PATTERN - 1; k >= 0; k--) begin
         if (5'(k) < cap_len && cfg.pattern[k] == 8'd0) begin
            eff_len = 5'(k);
         end
      end

      // Pattern byte k lines up with window entry eff_len-1-k.
      pos_plus  = {1'b0, pos_ff} + 17'd1;
      window_eq = (pos_plus >= {12'd0, eff_len});
      for (int k = 0; k < MAX_PATTERN; k++) begin
         lane_byte[k] = 8'd0;
         for (int j = 0; j < MAX_PATTERN; j++) begin
            if (5'(j + k + 1) == eff_len) begin
               lane_byte[k] = window_in[j];
            end
         end
         if (5'(k) < eff_len) begin
            if (cfg.exact_case) begin
               if (lane_byte[k] != cfg.pattern[k]) window_eq = 1'b0;
            end else begin
               if (fold(lane_byte[k]) != fold(cfg.pattern[k])) window_eq = 1'b0;
            end
         end
      end

      hit_in    = 1'b0;
      offset_in = 16'd0;
      guard_in  = guard_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      if (item.active) begin
         if (eff_len == 5'd0) begin
            hit_in    = 1'b1;
            offset_in = pos_ff;
         end else if (window_eq && guard_ff == 5'd0) begin
            hit_in    = 1'b1;
            offset_in = 16'(pos_plus - {12'd0, eff_len});
            guard_in  = eff_len - 5'd1;
         end else if (guard_ff != 5'd0) begin
            guard_in = guard_ff - 5'd1;
         end
         if (hit_in && !(&cnt_ff)) begin
            cnt_in = cnt_ff + 1'b1;
         end
         if (pos_ff != 16'hFFFF) begin
            pos_in = pos_ff + 16'd1;
         end
      end
      total_in = 16'(cnt_in);
      eos_in   = item.last_byte;

      out_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   // The window needs no clearing: a compare only looks at entries that were
   // written since the string began.
   always_ff @(posedge clock) begin
      if (fire && item.active) begin
         for (int j = 0; j < MAX_PATTERN; j++) begin
            window_ff[j] <= window_in[j];
         end
      end
      if (fire) begin
         hit_ff    <= hit_in;
         offset_ff <= offset_in;
         total_ff  <= total_in;
         eos_ff    <= eos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         guard_ff     <= 5'd0;
         pos_ff       <= 16'd0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            if (item.last_byte) begin
               guard_ff <= 5'd0;
               pos_ff   <= 16'd0;
               cnt_ff   <= '0;
            end else begin
               guard_ff <= guard_in;
               pos_ff   <= pos_in;
               cnt_ff   <= cnt_in;
            end
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {total_ff, offset_ff};
   assign rsp_tuser  = hit_ff;
   assign rsp_tlast  = eos_ff;

endmodule

// ===== rtl/substring_occurrence_counter.sv =====
// Top level of the substring occurrence counter: configuration registers,
// front end, queue and matcher. Depends on subcnt_pkg and the subcnt modules.
//
//   channel  direction  handshake           payload
//   req      in         req_tvalid/tready   tdata text byte, tlast last byte
//   rsp      out        rsp_tvalid/tready   tdata offset/total, tuser match,
//                                           tlast end of string
//   csr      in         csr_we              csr_index, csr_wdata
//
// One word is accepted per cycle while the queue has room, and each gives
// one result word; a byte waits in a queue slot, and its result is held in
// the result register. Reset is synchronous and clears the configuration to
// an empty, case-sensitive pattern. Either side may stall: the queue holds
// up to four words, and the input stalls only when it is full.
module substring_occurrence_counter #(
   parameter int MAX_PATTERN  = 16,
   parameter int COUNTER_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] match_offset, [31:16] match_total
   output logic        rsp_tuser,   // [0] match_end
   output logic        rsp_tlast,   // end_of_string
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import subcnt_pkg::*;

   localparam logic [1:0] CSR_PATTERN_LOW    = 2'd0;
   localparam logic [1:0] CSR_PATTERN_HIGH   = 2'd1;
   localparam logic [1:0] CSR_PATTERN_LENGTH = 2'd2;
   localparam logic [1:0] CSR_EXACT_CASE     = 2'd3;

   logic [63:0] pattern_low_ff;
   logic [63:0] pattern_high_ff;
   logic [4:0]  pattern_length_ff;
   logic        exact_case_ff;

   cfg_type     cfg;
   item_type    push_item;
   item_type    pop_item;
   logic        push;
   logic        pop;
   logic        queue_empty;
   logic        queue_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= 64'd0;
         pattern_high_ff   <= 64'd0;
         pattern_length_ff <= 5'd0;
         exact_case_ff     <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:    pattern_low_ff    <= csr_wdata;
            CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_wdata;
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_wdata[4:0];
            CSR_EXACT_CASE:     exact_case_ff     <= csr_wdata[0];
         endcase
      end
   end

   assign cfg.pattern    = {pattern_high_ff, pattern_low_ff};
   assign cfg.length     = pattern_length_ff;
   assign cfg.exact_case = exact_case_ff;

   subcnt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   subcnt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   subcnt_back #(
      .MAX_PATTERN  (MAX_PATTERN),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (!queue_empty),
      .item       (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
